### src/axpc_pkg.sv
// shared types, constants and helpers of the alpha xor pixel compositor
package axpc_pkg;

  localparam int unsigned PixW     = 8;
  localparam logic [7:0]  PixMax   = 8'hff;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned Lanes    = 3;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] lo;
    logic [7:0] quo;
  } axpc_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic                  sat;
    logic [7:0]            alpha;
    logic                  frame_end;
    axpc_lane_t [Lanes-1:0] lane;
  } axpc_div_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } axpc_pix_t;

  // rounded divide by 255 of t = x*y + 128
  function automatic logic [7:0] div255(input logic [15:0] t);
    logic [16:0] s;
    s = {1'b0, t} + {9'b0, t[15:8]};
    return s[15:8];
  endfunction

endpackage

### src/axpc_front.sv
// front pipeline: weights, rounded products, alpha and dividend per channel
module axpc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [7:0]             first_red,
  input  logic [7:0]             first_green,
  input  logic [7:0]             first_blue,
  input  logic [7:0]             first_alpha,
  input  logic [7:0]             second_red,
  input  logic [7:0]             second_green,
  input  logic [7:0]             second_blue,
  input  logic [7:0]             second_alpha,
  input  logic                   frame_end_in,
  output axpc_pkg::axpc_div_t    div_out
);

  logic [7:0] c1 [axpc_pkg::Lanes];
  logic [7:0] c2 [axpc_pkg::Lanes];

  // stage 1
  logic        s1_valid;
  logic        s1_frame;
  logic [7:0]  s1_w1;
  logic [7:0]  s1_w2;
  logic [15:0] s1_ta1;
  logic [15:0] s1_ta2;
  logic [15:0] s1_tc1 [axpc_pkg::Lanes];
  logic [15:0] s1_tc2 [axpc_pkg::Lanes];

  // stage 2
  logic        s2_valid;
  logic        s2_frame;
  logic [7:0]  s2_w1;
  logic [7:0]  s2_w2;
  logic [7:0]  s2_alpha;
  logic [7:0]  s2_mc1 [axpc_pkg::Lanes];
  logic [7:0]  s2_mc2 [axpc_pkg::Lanes];
  logic [8:0]  alpha_sum;

  // stage 3
  logic        s3_valid;
  logic        s3_frame;
  logic [7:0]  s3_alpha;
  logic [15:0] s3_p1 [axpc_pkg::Lanes];
  logic [15:0] s3_p2 [axpc_pkg::Lanes];

  // stage 4
  logic [16:0] num [axpc_pkg::Lanes];
  logic        over [axpc_pkg::Lanes];
  logic [15:0] dvd [axpc_pkg::Lanes];
  axpc_pkg::axpc_div_t s4, s4_next;

  assign c1[0] = first_red;
  assign c1[1] = first_green;
  assign c1[2] = first_blue;
  assign c2[0] = second_red;
  assign c2[1] = second_green;
  assign c2[2] = second_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4.valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frame <= frame_end_in;
      s1_w1    <= axpc_pkg::PixMax - second_alpha;
      s1_w2    <= axpc_pkg::PixMax - first_alpha;
      s1_ta1   <= first_alpha * (axpc_pkg::PixMax - second_alpha) + 16'd128;
      s1_ta2   <= second_alpha * (axpc_pkg::PixMax - first_alpha) + 16'd128;
      for (int k = 0; k < axpc_pkg::Lanes; k++) begin
        s1_tc1[k] <= c1[k] * first_alpha + 16'd128;
        s1_tc2[k] <= c2[k] * second_alpha + 16'd128;
      end
    end
  end

  assign alpha_sum = {1'b0, axpc_pkg::div255(s1_ta1)} + {1'b0, axpc_pkg::div255(s1_ta2)};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_frame <= s1_frame;
      s2_w1    <= s1_w1;
      s2_w2    <= s1_w2;
      s2_alpha <= alpha_sum[8] ? axpc_pkg::PixMax : alpha_sum[7:0];
      for (int k = 0; k < axpc_pkg::Lanes; k++) begin
        s2_mc1[k] <= axpc_pkg::div255(s1_tc1[k]);
        s2_mc2[k] <= axpc_pkg::div255(s1_tc2[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_frame <= s2_frame;
      s3_alpha <= s2_alpha;
      for (int k = 0; k < axpc_pkg::Lanes; k++) begin
        s3_p1[k] <= s2_mc1[k] * s2_w1;
        s3_p2[k] <= s2_mc2[k] * s2_w2;
      end
    end
  end

  always_comb begin
    s4_next           = s4;
    s4_next.frame_end = s3_frame;
    s4_next.alpha     = s3_alpha;
    s4_next.zero      = (s3_alpha == 8'd0);
    s4_next.sat       = 1'b0;
    for (int k = 0; k < axpc_pkg::Lanes; k++) begin
      num[k]  = {1'b0, s3_p1[k]} + {1'b0, s3_p2[k]};
      over[k] = (num[k] >= {1'b0, s3_alpha, 8'd0});
      // quotient only computed when it fits in eight bits
      dvd[k]  = (over[k] || s4_next.zero) ? 16'd0 : num[k][15:0];
      s4_next.lane[k].rem = dvd[k][15:8];
      s4_next.lane[k].lo  = dvd[k][7:0];
      s4_next.lane[k].quo = 8'd0;
    end
  end

  // a saturated lane enters the chain with all quotient ones
  always_ff @(posedge clk) begin
    if (en) begin
      s4.frame_end <= s4_next.frame_end;
      s4.alpha     <= s4_next.alpha;
      s4.zero      <= s4_next.zero;
      s4.sat       <= 1'b0;
      for (int k = 0; k < axpc_pkg::Lanes; k++) begin
        s4.lane[k].rem <= s4_next.lane[k].rem;
        s4.lane[k].lo  <= s4_next.lane[k].lo;
        s4.lane[k].quo <= over[k] ? axpc_pkg::PixMax : 8'd0;
      end
    end
  end

  assign div_out = s4;

endmodule

### src/axpc_div_cell.sv
// one restoring division step for all three colour lanes
module axpc_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  axpc_pkg::axpc_div_t d_in,
  output axpc_pkg::axpc_div_t d_out
);

  axpc_pkg::axpc_div_t d_reg, d_next;
  logic [8:0] trial [axpc_pkg::Lanes];
  logic [8:0] diff  [axpc_pkg::Lanes];
  logic       fit   [axpc_pkg::Lanes];
  logic       sat_l [axpc_pkg::Lanes];

  always_comb begin
    d_next = d_in;
    for (int k = 0; k < axpc_pkg::Lanes; k++) begin
      // a saturated lane enters with all quotient ones and a zero dividend
      sat_l[k] = (d_in.lane[k].quo == axpc_pkg::PixMax) &&
                 (d_in.lane[k].rem == 8'd0) && (d_in.lane[k].lo == 8'd0);
      trial[k] = {d_in.lane[k].rem, d_in.lane[k].lo[7]};
      diff[k]  = trial[k] - {1'b0, d_in.alpha};
      fit[k]   = (trial[k] >= {1'b0, d_in.alpha});
      d_next.lane[k].rem = fit[k] ? diff[k][7:0] : trial[k][7:0];
      d_next.lane[k].lo  = {d_in.lane[k].lo[6:0], 1'b0};
      d_next.lane[k].quo = sat_l[k] ? axpc_pkg::PixMax
                                    : {d_in.lane[k].quo[6:0], fit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_reg.valid <= 1'b0;
    end else if (en) begin
      d_reg.valid <= d_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_reg.zero      <= d_next.zero;
      d_reg.sat       <= d_next.sat;
      d_reg.alpha     <= d_next.alpha;
      d_reg.frame_end <= d_next.frame_end;
      d_reg.lane      <= d_next.lane;
    end
  end

  assign d_out = d_reg;

endmodule

### src/axpc_out.sv
// result formatting and output register with skid stage
module axpc_out (
  input  logic                clk,
  input  logic                rst,
  input  axpc_pkg::axpc_div_t d_in,
  output logic                en,
  output logic                out_valid,
  input  logic                out_ready,
  output axpc_pkg::axpc_pix_t pix
);

  axpc_pkg::axpc_pix_t res, main_q, skid_q;
  logic main_valid;
  logic skid_valid;
  logic push;

  always_comb begin
    res.alpha     = d_in.alpha;
    res.frame_end = d_in.frame_end;
    res.red       = d_in.zero ? 8'd0 : d_in.lane[0].quo;
    res.green     = d_in.zero ? 8'd0 : d_in.lane[1].quo;
    res.blue      = d_in.zero ? 8'd0 : d_in.lane[2].quo;
  end

  assign en   = ~skid_valid;
  assign push = d_in.valid & ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_q <= skid_valid ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid = main_valid;
  assign pix       = main_q;

endmodule

### src/alpha_xor_pixel_composite.sv
// top level of the porter-duff xor compositor for rgba8 pixel pairs
// throughput: one pixel pair per cycle while the output does not stall, set by the
// fully pipelined 8-cell divider chain
// a stalled output holds the pipeline; a skid stage keeps in_ready registered
// reset: synchronous, clears only the valid bits; data registers are not reset
module alpha_xor_pixel_composite (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] first_red,
  input  logic [7:0] first_green,
  input  logic [7:0] first_blue,
  input  logic [7:0] first_alpha,
  input  logic [7:0] second_red,
  input  logic [7:0] second_green,
  input  logic [7:0] second_blue,
  input  logic [7:0] second_alpha,
  input  logic       frame_end_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       frame_end_out
);

  logic en;
  axpc_pkg::axpc_div_t chain [axpc_pkg::DivSteps+1];
  axpc_pkg::axpc_pix_t pix;

  assign in_ready = en;

  axpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .first_alpha  (first_alpha),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .second_alpha (second_alpha),
    .frame_end_in (frame_end_in),
    .div_out      (chain[0])
  );

  for (genvar i = 0; i < axpc_pkg::DivSteps; i++) begin : g_cell
    axpc_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  axpc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .d_in      (chain[axpc_pkg::DivSteps]),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix       (pix)
  );

  assign out_red       = pix.red;
  assign out_green     = pix.green;
  assign out_blue      = pix.blue;
  assign out_alpha     = pix.alpha;
  assign frame_end_out = pix.frame_end;

endmodule

### src/axpc_checker.sv
// port-level checks of the compositor and their binding
module axpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       frame_end_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(frame_end_out))
    else $error("stalled output changed");

  // transparent result has black colour
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_alpha == 8'd0 |-> out_red == 8'd0 && out_green == 8'd0 &&
      out_blue == 8'd0)
    else $error("nonzero colour with zero alpha");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input only blocks while a result waits
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // input stall lasts only while output is stalled
  a_ready_recovers: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("input stall outlived output transfer");

endmodule

bind alpha_xor_pixel_composite axpc_checker u_axpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_alpha     (out_alpha),
  .frame_end_out (frame_end_out)
);
